>>> hdl/dpr_pkg.sv
package dpr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COEF_W         = 32;
    localparam int ACC_W          = 64;
    localparam int DEPTH_W        = 16;
    localparam int COLOR_W        = 8;
    localparam int SIZE_W         = 13;
    localparam int CFG_ADDR_W     = 6;
    localparam int CFG_DATA_W     = 64;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    typedef enum logic [2:0] {
        REG_U_COL_ROW     = 3'd0,
        REG_U_DEPTH_CONST = 3'd1,
        REG_V_COL_ROW     = 3'd2,
        REG_V_DEPTH_CONST = 3'd3,
        REG_Z_COL_ROW     = 3'd4,
        REG_Z_DEPTH_CONST = 3'd5,
        REG_TARGET_WIDTH  = 3'd6,
        REG_TARGET_HEIGHT = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } color_t;

endpackage

>>> hdl/dpr_divider.sv
module dpr_divider
    import dpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                       clk,
    input  logic [ACC_W+COORD_BITS-1:0] num,
    input  logic [ACC_W-1:0]           den,
    output logic [COORD_BITS-1:0]      quot
);

    localparam int REM_W = ACC_W + COORD_BITS;

    logic [REM_W-1:0]      rem_reg [COORD_BITS];
    logic [ACC_W-1:0]      den_reg [COORD_BITS];
    logic [COORD_BITS-1:0] q_reg   [COORD_BITS];

    logic [REM_W-1:0]      rem_in  [COORD_BITS];
    logic [ACC_W-1:0]      den_in  [COORD_BITS];
    logic [COORD_BITS-1:0] q_in    [COORD_BITS];

    // One quotient bit per stage, most significant first; the numerator is
    // known to be below den << COORD_BITS, so COORD_BITS bits suffice.
    for (genvar k = 0; k < COORD_BITS; k++)
    begin : g_stage
        logic [REM_W-1:0]      sub;
        logic                  ge;
        logic [REM_W-1:0]      rem_next;
        logic [COORD_BITS-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign rem_in[k] = num;
            assign den_in[k] = den;
            assign q_in[k]   = '0;
        end
        else
        begin : g_rest
            assign rem_in[k] = rem_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign q_in[k]   = q_reg[k-1];
        end

        always_comb
        begin
            sub      = {{COORD_BITS{1'b0}}, den_in[k]} << (COORD_BITS - 1 - k);
            ge       = (rem_in[k] >= sub);
            rem_next = ge ? (rem_in[k] - sub) : rem_in[k];
            q_next   = {q_in[k][COORD_BITS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_in[k];
            q_reg[k]   <= q_next;
        end
    end

    assign quot = q_reg[COORD_BITS-1];

endmodule

>>> hdl/depth_pixel_reprojection.sv
// Depth pixel reprojection into a second camera image.
//
// Input channel: drive pixel_col, pixel_row, depth_mm and the color with
// start high; a beat is taken at every edge where start is high and busy is
// low. busy stays low, so a new pixel may enter on every clock.
// Result channel: result_strobe is high for exactly one cycle with target_u,
// target_v and the pixel color; the receiver must take it in that cycle.
// Pixels with zero depth, a non-positive denominator or a target outside
// target_width x target_height produce no beat at all.
// The pipeline sustains one pixel per cycle. Its stages are: depth products,
// nine coefficient products, two adder levels, range check, then a
// COORD_BITS-stage divider that resolves one quotient bit per stage, and
// the output register.
// Configuration sits on an APB port, register i at byte address 8*i with
// 64-bit data; write it only while no pixel is in flight.
// Reset clears the pipeline valid bits, zeroes the coefficients and loads
// a 640 x 480 target size.
module depth_pixel_reprojection
    import dpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] pixel_col,
    input  logic [COORD_BITS-1:0] pixel_row,
    input  logic [DEPTH_W-1:0]    depth_mm,
    input  logic [COLOR_W-1:0]    red,
    input  logic [COLOR_W-1:0]    green,
    input  logic [COLOR_W-1:0]    blue,
    output logic                  result_strobe,
    output logic [COORD_BITS-1:0] target_u,
    output logic [COORD_BITS-1:0] target_v,
    output logic [COLOR_W-1:0]    out_red,
    output logic [COLOR_W-1:0]    out_green,
    output logic [COLOR_W-1:0]    out_blue,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PROD_W = COORD_BITS + DEPTH_W;
    localparam int MULW   = COEF_W + PROD_W + 1;
    localparam int MULD_W = COEF_W + DEPTH_W + 1;
    localparam int REM_W  = ACC_W + COORD_BITS;
    localparam int LW     = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
    localparam int LAT    = COORD_BITS + 6;

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] ucr_reg, udc_reg, vcr_reg, vdc_reg, zcr_reg, zdc_reg;
    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic                  cfg_wr;
    reg_index_t            cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucr_reg    <= '0;
            udc_reg    <= '0;
            vcr_reg    <= '0;
            vdc_reg    <= '0;
            zcr_reg    <= '0;
            zdc_reg    <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_U_COL_ROW:     ucr_reg    <= pwdata;
                REG_U_DEPTH_CONST: udc_reg    <= pwdata;
                REG_V_COL_ROW:     vcr_reg    <= pwdata;
                REG_V_DEPTH_CONST: vdc_reg    <= pwdata;
                REG_Z_COL_ROW:     zcr_reg    <= pwdata;
                REG_Z_DEPTH_CONST: zdc_reg    <= pwdata;
                REG_TARGET_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_TARGET_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_U_COL_ROW:     prdata = ucr_reg;
            REG_U_DEPTH_CONST: prdata = udc_reg;
            REG_V_COL_ROW:     prdata = vcr_reg;
            REG_V_DEPTH_CONST: prdata = vdc_reg;
            REG_Z_COL_ROW:     prdata = zcr_reg;
            REG_Z_DEPTH_CONST: prdata = zdc_reg;
            REG_TARGET_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_TARGET_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- stage 1: depth products ----------------
    // Drop zero-depth pixels right at the door.
    logic                 v1_reg;
    logic [PROD_W-1:0]    cd1_reg, rd1_reg;
    logic [DEPTH_W-1:0]   d1_reg;
    color_t               c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy && (depth_mm != '0);
    end

    always_ff @(posedge clk)
    begin
        cd1_reg <= pixel_col * depth_mm;
        rd1_reg <= pixel_row * depth_mm;
        d1_reg  <= depth_mm;
        c1_reg  <= '{r: red, g: green, b: blue};
    end

    // ---------------- stage 2: coefficient products ----------------
    logic signed [MULW-1:0]   pu0, pu1, pv0, pv1, pz0, pz1;
    logic signed [MULD_W-1:0] pu2, pv2, pz2;

    assign pu0 = $signed(ucr_reg[31:0])  * $signed({1'b0, cd1_reg});
    assign pu1 = $signed(ucr_reg[63:32]) * $signed({1'b0, rd1_reg});
    assign pu2 = $signed(udc_reg[31:0])  * $signed({1'b0, d1_reg});
    assign pv0 = $signed(vcr_reg[31:0])  * $signed({1'b0, cd1_reg});
    assign pv1 = $signed(vcr_reg[63:32]) * $signed({1'b0, rd1_reg});
    assign pv2 = $signed(vdc_reg[31:0])  * $signed({1'b0, d1_reg});
    assign pz0 = $signed(zcr_reg[31:0])  * $signed({1'b0, cd1_reg});
    assign pz1 = $signed(zcr_reg[63:32]) * $signed({1'b0, rd1_reg});
    assign pz2 = $signed(zdc_reg[31:0])  * $signed({1'b0, d1_reg});

    logic             v2_reg;
    logic [ACC_W-1:0] pu0_reg, pu1_reg, pu2_reg;
    logic [ACC_W-1:0] pv0_reg, pv1_reg, pv2_reg;
    logic [ACC_W-1:0] pz0_reg, pz1_reg, pz2_reg;
    color_t           c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    // Sign-extend (or wrap) each product into the 64-bit accumulator.
    always_ff @(posedge clk)
    begin
        pu0_reg <= ACC_W'(pu0);
        pu1_reg <= ACC_W'(pu1);
        pu2_reg <= ACC_W'(pu2);
        pv0_reg <= ACC_W'(pv0);
        pv1_reg <= ACC_W'(pv1);
        pv2_reg <= ACC_W'(pv2);
        pz0_reg <= ACC_W'(pz0);
        pz1_reg <= ACC_W'(pz1);
        pz2_reg <= ACC_W'(pz2);
        c2_reg  <= c1_reg;
    end

    // ---------------- stage 3: first adder level ----------------
    logic             v3_reg;
    logic [ACC_W-1:0] su0_reg, su1_reg, sv0_reg, sv1_reg, sz0_reg, sz1_reg;
    color_t           c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        su0_reg <= pu0_reg + pu1_reg;
        su1_reg <= pu2_reg + ACC_W'($signed(udc_reg[63:32]));
        sv0_reg <= pv0_reg + pv1_reg;
        sv1_reg <= pv2_reg + ACC_W'($signed(vdc_reg[63:32]));
        sz0_reg <= pz0_reg + pz1_reg;
        sz1_reg <= pz2_reg + ACC_W'($signed(zdc_reg[63:32]));
        c3_reg  <= c2_reg;
    end

    // ---------------- stage 4: row sums ----------------
    logic             v4_reg;
    logic [ACC_W-1:0] nu_reg, nv_reg, den_reg;
    color_t           c4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        nu_reg  <= su0_reg + su1_reg;
        nv_reg  <= sv0_reg + sv1_reg;
        den_reg <= sz0_reg + sz1_reg;
        c4_reg  <= c3_reg;
    end

    // ---------------- stage 5: shift by one denominator, range check ----
    // floor(N/D)+1 = floor((N+D)/D); it is a valid coordinate only when
    // 0 <= N+D < D << COORD_BITS, which also bounds the divider.
    logic [ACC_W:0]   mu, mv;
    logic [REM_W-1:0] den_top;
    logic             den_pos, mu_ok, mv_ok;

    always_comb
    begin
        mu      = {nu_reg[ACC_W-1], nu_reg} + {1'b0, den_reg};
        mv      = {nv_reg[ACC_W-1], nv_reg} + {1'b0, den_reg};
        den_top = {den_reg, {COORD_BITS{1'b0}}};
        den_pos = !den_reg[ACC_W-1] && (den_reg != '0);
        mu_ok   = !mu[ACC_W] && (REM_W'(mu[ACC_W-1:0]) < den_top);
        mv_ok   = !mv[ACC_W] && (REM_W'(mv[ACC_W-1:0]) < den_top);
    end

    logic             v5_reg;
    logic [REM_W-1:0] mu5_reg, mv5_reg;
    logic [ACC_W-1:0] den5_reg;
    color_t           c5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg && den_pos && mu_ok && mv_ok;
    end

    always_ff @(posedge clk)
    begin
        mu5_reg  <= REM_W'(mu[ACC_W-1:0]);
        mv5_reg  <= REM_W'(mv[ACC_W-1:0]);
        den5_reg <= den_reg;
        c5_reg   <= c4_reg;
    end

    // ---------------- divider stages ----------------
    logic [COORD_BITS-1:0] qu, qv;

    dpr_divider #(.COORD_BITS(COORD_BITS)) u_div_u
    (
        .clk  (clk),
        .num  (mu5_reg),
        .den  (den5_reg),
        .quot (qu)
    );

    dpr_divider #(.COORD_BITS(COORD_BITS)) u_div_v
    (
        .clk  (clk),
        .num  (mv5_reg),
        .den  (den5_reg),
        .quot (qv)
    );

    // Valid and color ride alongside the divider, one slot per stage.
    logic   dv_reg [COORD_BITS];
    color_t dc_reg [COORD_BITS];

    for (genvar k = 0; k < COORD_BITS; k++)
    begin : g_line
        if (k == 0)
        begin : g_head
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[k] <= 1'b0;
                else
                    dv_reg[k] <= v5_reg;
            end
            always_ff @(posedge clk)
            begin
                dc_reg[k] <= c5_reg;
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[k] <= 1'b0;
                else
                    dv_reg[k] <= dv_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                dc_reg[k] <= dc_reg[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    // Drop coordinates outside the configured target size.
    logic                  strobe_reg;
    logic [COORD_BITS-1:0] u_reg, v_reg;
    color_t                co_reg;
    logic                  in_frame;

    assign in_frame = (LW'(qu) < LW'(width_reg)) && (LW'(qv) < LW'(height_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= dv_reg[COORD_BITS-1] && in_frame;
    end

    always_ff @(posedge clk)
    begin
        u_reg  <= qu;
        v_reg  <= qv;
        co_reg <= dc_reg[COORD_BITS-1];
    end

    assign result_strobe = strobe_reg;
    assign target_u      = u_reg;
    assign target_v      = v_reg;
    assign out_red       = co_reg.r;
    assign out_green     = co_reg.g;
    assign out_blue      = co_reg.b;

    // ---------------- assertions ----------------
    a_u_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (LW'(target_u) < LW'(width_reg)))
        else $error("emitted column outside target width");

    a_v_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (LW'(target_v) < LW'(height_reg)))
        else $error("emitted row outside target height");

    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start, LAT) && ($past(depth_mm, LAT) == '0)) |-> !result_strobe)
        else $error("beat emitted for a zero-depth pixel");

    a_color_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ((out_red == $past(red, LAT)) &&
                           (out_green == $past(green, LAT)) &&
                           (out_blue == $past(blue, LAT))))
        else $error("color does not match the pixel that entered");

endmodule
